// ===== sv/swah_pkg.sv =====
// Shared types, constants and coefficient builder for the swept wah band-pass.
`timescale 1ns / 1ps
`default_nettype none
package swah_pkg;

	// serial multiplier geometry
	localparam int AW    = 40;           // signed multiplicand width
	localparam int BW    = 32;           // unsigned multiplier width
	localparam int PW    = 72;           // signed product width
	localparam int DIGIT = 4;            // multiplier bits retired per cycle
	localparam int NDIG  = BW / DIGIT;   // digits per product
	localparam int CW    = $clog2(NDIG);

	// configuration register indexes
	localparam logic [2:0] REG_ENV_SENS = 3'd0;
	localparam logic [2:0] REG_PEDAL    = 3'd1;
	localparam logic [2:0] REG_AUTO     = 3'd2;
	localparam logic [2:0] REG_ATTACK   = 3'd3;
	localparam logic [2:0] REG_RELEASE  = 3'd4;

	// fixed gains and mixing constants
	localparam logic [BW-1:0] OUT_GAIN   = 32'd511606399;
	localparam logic [BW-1:0] DRY_GAIN   = 32'd128849019;
	localparam logic [BW-1:0] PEDAL_MIX  = 32'd45875;
	localparam logic [BW-1:0] ENV_MIX    = 32'd19661;
	localparam logic [16:0]   AUTO_BASE  = 17'd14418;
	localparam logic [16:0]   POS_FULL   = 17'd65536;

	// coefficient builder constants, Q2.30
	localparam longint unsigned ONE30       = 64'd1073741824;
	localparam longint unsigned PI_Q30      = 64'd3373259426;
	localparam longint unsigned LN2_Q30     = 64'd744261118;
	localparam longint unsigned LOG2_14_Q30 = 64'd4088116219;
	localparam longint unsigned K_Q30       = 64'd315806344;
	localparam longint unsigned WMAX_Q30    = 64'd483183821;

	typedef struct packed {
		logic [31:0] a1;
		logic [31:0] a2;
		logic [31:0] a3;
	} coef_t;

	typedef struct packed {
		logic busy;
		logic done;
	} smul_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENV1,
		S_ENV2,
		S_SE,
		S_MAN1,
		S_MAN2,
		S_IDX,
		S_ROM,
		S_BP1,
		S_BP2,
		S_BP3,
		S_BP4,
		S_Y1,
		S_Y2,
		S_OUT
	} fsm_t;

	function automatic longint unsigned mulq(input longint unsigned a,
		input longint unsigned b);
		return (a * (b >> 15) + ((a * (b & 64'd32767)) >> 15)) >> 15;
	endfunction

	// restoring long division, table build only
	function automatic longint unsigned udiv(input longint unsigned num,
		input longint unsigned dvs);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= dvs) begin
				r = r - dvs;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// one table entry: cutoff 120*14^p clamped, TPT warp and band-pass terms
	function automatic coef_t coef_entry(input int unsigned i, input int unsigned rate,
		input int unsigned steps);
		longint unsigned p, y, t, m, term, w, th, th2, g, den, a1, a2, a3;
		longint s, c, st, ct;
		int unsigned n, k;
		coef_t r;
		p = udiv(longint'(i) * ONE30, longint'(steps - 1));
		y = mulq(p, LOG2_14_Q30);
		n = int'((y >> 30) & 64'd3);
		t = mulq(y & (ONE30 - 64'd1), LN2_Q30);
		m = ONE30;
		term = ONE30;
		for (k = 1; k <= 14; k++) begin
			term = udiv(mulq(term, t), longint'(k));
			m = m + term;
		end
		w = udiv((64'd120 * m) << n, longint'(rate));
		if (w > WMAX_Q30) w = WMAX_Q30;
		th = mulq(w, PI_Q30);
		th2 = mulq(th, th);
		s = longint'(th);
		st = longint'(th);
		c = longint'(ONE30);
		ct = longint'(ONE30);
		for (k = 1; k <= 10; k++) begin
			st = longint'(udiv(mulq(longint'(st), th2), longint'((2 * k) * (2 * k + 1))));
			ct = longint'(udiv(mulq(longint'(ct), th2), longint'((2 * k - 1) * (2 * k))));
			if (k[0]) begin
				s = s - st;
				c = c - ct;
			end else begin
				s = s + st;
				c = c + ct;
			end
		end
		if (s < 0) s = 0;
		if (c < 1) c = 1;
		g = udiv(longint'(s) << 30, longint'(c));
		den = ONE30 + mulq(g, g + K_Q30);
		a1 = udiv(ONE30 << 30, den);
		a2 = mulq(g, a1);
		a3 = mulq(g, a2);
		r.a1 = a1[31:0];
		r.a2 = a2[31:0];
		r.a3 = a3[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/swah_smul.sv =====
// Digit-serial signed-by-unsigned multiplier, four multiplier bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module swah_smul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [swah_pkg::AW-1:0]   a,
	input  logic        [swah_pkg::BW-1:0]   b,
	output swah_pkg::smul_stat_t             stat,
	output logic signed [swah_pkg::PW-1:0]   prod
);
	import swah_pkg::*;

	logic               busy_q, done_q;
	logic [CW-1:0]      cnt_q;
	logic signed [PW-1:0] a_q, acc_q, part;
	logic [BW-1:0]      b_q;
	logic signed [DIGIT:0] dig_s;

	assign dig_s = $signed({1'b0, b_q[DIGIT-1:0]});
	assign part  = a_q * dig_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NDIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part;
			a_q   <= a_q <<< DIGIT;
			b_q   <= b_q >> DIGIT;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

endmodule
`default_nettype wire

// ===== sv/swah_coef_rom.sv =====
// Coefficient ROM indexed by sweep position, registered read.
`timescale 1ns / 1ps
`default_nettype none
module swah_coef_rom #(
	parameter int SAMPLE_RATE    = 48000,
	parameter int POSITION_STEPS = 256
) (
	input  logic                              clk,
	input  logic [$clog2(POSITION_STEPS)-1:0] idx,
	output swah_pkg::coef_t                   coef
);
	import swah_pkg::*;

	coef_t tab [POSITION_STEPS];

	for (genvar gi = 0; gi < POSITION_STEPS; gi++) begin : g_ent
		localparam coef_t ENT = coef_entry(gi, SAMPLE_RATE, POSITION_STEPS);
		assign tab[gi] = ENT;
	end

	always_ff @(posedge clk) begin
		coef <= tab[idx];
	end

endmodule
`default_nettype wire

// ===== sv/envelope_swept_wah_bandpass.sv =====
// Top level of the envelope-swept wah band-pass: sequencer, state and datapath.
//
//  channel      | handshake                          | payload
//  -------------+------------------------------------+-----------------------
//  sample in    | sample_in_valid / sample_in_stall  | sample_in  (signed)
//  sample out   | sample_out_valid / sample_out_stall| sample_out (signed)
//  config write | cfg_wen                            | cfg_idx, cfg_wdata
//
// One sample takes ten products with the envelope sweep and twelve with the
// pedal sweep, all through the one shared digit-serial multiplier, plus the
// accept, ROM read and output load steps.
// Reset clears the envelope, both integrators and the handshake state, and
// loads the register defaults. A stalled output holds its value; the next
// sample is taken while it waits and stops only at the output load.
`timescale 1ns / 1ps
`default_nettype none
module envelope_swept_wah_bandpass #(
	parameter int SAMPLE_RATE    = 48000,
	parameter int POSITION_STEPS = 256,
	parameter int SAMPLE_BITS    = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_in_valid,
	output logic                          sample_in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          sample_out_valid,
	input  logic                          sample_out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_wen,
	input  logic [2:0]                    cfg_idx,
	input  logic [15:0]                   cfg_wdata
);
	import swah_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int FRAC = SB - 1;
	localparam int IW   = $clog2(POSITION_STEPS);
	localparam int RW   = PW - 30;   // width after the Q30 rounding shift
	localparam int VW   = AW;        // filter temporaries
	localparam int YW   = 48;
	// sample to Q5.27 and back
	localparam int XUP  = (FRAC <= 27) ? 27 - FRAC : 0;
	localparam int XDN  = (FRAC > 27) ? FRAC - 27 : 0;
	localparam int XRND = (XDN > 0) ? (1 << (XDN - 1)) : 0;
	localparam int YUP  = (FRAC >= 27) ? FRAC - 27 : 0;
	localparam int YDN  = (FRAC < 27) ? 27 - FRAC : 0;
	localparam int YRND = (YDN > 0) ? (1 << (YDN - 1)) : 0;

	// sat32 to the integrator range
	function automatic logic signed [31:0] sat32(input logic signed [VW+2:0] v);
		logic signed [VW+2:0] hi, lo;
		hi = (VW+3)'(33'sh07fffffff);
		lo = -(VW+3)'(33'sh080000000);
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[31:0];
	endfunction

	// control and configuration
	fsm_t        state_q, state_d;
	logic [15:0] sens_q, pedal_q, attack_q, release_q;
	logic        auto_q;
	logic        out_valid_q, out_free, in_take;

	// filter state
	logic [SB-1:0]        env_q;
	logic signed [31:0]   i1_q, i2_q;

	// per-sample temporaries
	logic [SB-1:0]        mag_q;
	logic [15:0]          csel_q;
	logic signed [SB-1:0] x_q;
	logic signed [PW-1:0] t0_q;
	logic [16:0]          se_q, pos_q;
	logic [IW-1:0]        idx_q;
	logic signed [VW-1:0] v1_q, v2_q, v3_q;
	logic signed [RW-1:0] y_q;
	logic signed [SB-1:0] res_q;

	// multiplier hookup
	logic                 mul_start;
	logic signed [AW-1:0] mul_a;
	logic [BW-1:0]        mul_b;
	smul_stat_t           mstat;
	logic signed [PW-1:0] prod;
	coef_t                coef;
	logic                 op_state;

	// combinational datapath
	logic [SB-1:0]        mag_in;
	logic [15:0]          csel_in;
	logic signed [PW-1:0] sum16, rnd16, rnd_se, rnd30;
	logic [SB-1:0]        env_new;
	logic [SB+1:0]        e3;
	logic [SB-1:0]        e_val;
	logic [16:0]          se_new, pos_auto, pos_man;
	logic [18:0]          se3;
	logic signed [RW-1:0] rs30;
	logic signed [YW-1:0] xe, x27w;
	logic signed [VW-1:0] x27, v3_new, v1_new, v2_new;
	logic signed [VW+2:0] i1_pre, i2_pre;
	logic signed [RW:0]   y_sum;
	logic signed [YW-1:0] ye, ys, lim_hi, lim_lo;
	logic signed [SB-1:0] y_sat;

	swah_smul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mstat),
		.prod   (prod)
	);

	swah_coef_rom #(
		.SAMPLE_RATE    (SAMPLE_RATE),
		.POSITION_STEPS (POSITION_STEPS)
	) u_rom (
		.clk  (clk),
		.idx  (idx_q),
		.coef (coef)
	);

	assign sample_in_stall  = (state_q != S_IDLE);
	assign in_take          = sample_in_valid && !sample_in_stall;
	assign out_free         = !out_valid_q || !sample_out_stall;
	assign sample_out_valid = out_valid_q;

	always_comb begin
		// rectify the incoming sample; the most negative code maps to full scale
		mag_in  = sample_in[SB-1] ? SB'(~sample_in + 1'b1) : SB'(sample_in);
		csel_in = (mag_in > env_q) ? attack_q : release_q;

		// shared rounding adds on the product
		sum16   = t0_q + prod + PW'(32768);
		env_new = sum16[16 +: SB];
		pos_man = sum16[16 +: 17];
		rnd16   = prod + PW'(32768);

		// scale the envelope by three and clamp to full scale
		e3    = {2'b00, env_q} + {1'b0, env_q, 1'b0};
		e_val = (e3 > ((SB+2)'(1) << FRAC)) ? (SB'(1) << FRAC) : e3[SB-1:0];

		rnd_se   = prod + (PW'(1) << (FRAC - 1));
		se_new   = rnd_se[FRAC +: 17];
		se3      = {2'b00, se_new} + {1'b0, se_new, 1'b0} + 19'd2;
		pos_auto = AUTO_BASE + 17'(se3[18:2]);

		rnd30 = prod + (PW'(1) <<< 29);
		rs30  = rnd30[PW-1:30];

		// sample into Q5.27
		xe   = YW'(x_q);
		x27w = ((xe + YW'(XRND)) >>> XDN) <<< XUP;
		x27  = VW'(x27w);
		v3_new = x27 - VW'(i2_q);

		v1_new = v1_q + VW'(rs30);
		v2_new = v2_q + VW'(rs30);
		i1_pre = ((VW+3)'(v1_q) <<< 1) - (VW+3)'(i1_q);
		i2_pre = ((VW+3)'(v2_new) <<< 1) - (VW+3)'(i2_q);

		// wet plus dry, back to the sample format, saturate
		y_sum  = (RW+1)'(y_q) + (RW+1)'(rs30);
		ye     = YW'(y_sum);
		ys     = ((ye + YW'(YRND)) >>> YDN) <<< YUP;
		lim_hi = (YW'(1) <<< FRAC) - YW'(1);
		lim_lo = -(YW'(1) <<< FRAC);
		if (ys > lim_hi)      y_sat = lim_hi[SB-1:0];
		else if (ys < lim_lo) y_sat = lim_lo[SB-1:0];
		else                  y_sat = ys[SB-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_take) state_d = S_ENV1;
			S_ENV1: if (mstat.done) state_d = S_ENV2;
			S_ENV2: if (mstat.done) state_d = S_SE;
			S_SE:   if (mstat.done) state_d = auto_q ? S_IDX : S_MAN1;
			S_MAN1: if (mstat.done) state_d = S_MAN2;
			S_MAN2: if (mstat.done) state_d = S_IDX;
			S_IDX:  if (mstat.done) state_d = S_ROM;
			S_ROM:  state_d = S_BP1;
			S_BP1:  if (mstat.done) state_d = S_BP2;
			S_BP2:  if (mstat.done) state_d = S_BP3;
			S_BP3:  if (mstat.done) state_d = S_BP4;
			S_BP4:  if (mstat.done) state_d = S_Y1;
			S_Y1:   if (mstat.done) state_d = S_Y2;
			S_Y2:   if (mstat.done) state_d = S_OUT;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// multiplier operands per step
	always_comb begin
		op_state = 1'b1;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			S_ENV1: begin
				mul_a = AW'({1'b0, env_q});
				mul_b = BW'(csel_q);
			end
			S_ENV2: begin
				mul_a = AW'({1'b0, mag_q});
				mul_b = BW'(17'd65536 - {1'b0, csel_q});
			end
			S_SE: begin
				mul_a = AW'({1'b0, e_val});
				mul_b = BW'(sens_q);
			end
			S_MAN1: begin
				mul_a = AW'({1'b0, pedal_q});
				mul_b = PEDAL_MIX;
			end
			S_MAN2: begin
				mul_a = AW'({1'b0, se_q});
				mul_b = ENV_MIX;
			end
			S_IDX: begin
				mul_a = AW'({1'b0, pos_q});
				mul_b = BW'(POSITION_STEPS - 1);
			end
			S_BP1: begin
				mul_a = AW'(i1_q);
				mul_b = coef.a1;
			end
			S_BP2: begin
				mul_a = v3_q;
				mul_b = coef.a2;
			end
			S_BP3: begin
				mul_a = AW'(i1_q);
				mul_b = coef.a2;
			end
			S_BP4: begin
				mul_a = v3_q;
				mul_b = coef.a3;
			end
			S_Y1: begin
				mul_a = v1_q;
				mul_b = OUT_GAIN;
			end
			S_Y2: begin
				mul_a = x27;
				mul_b = DRY_GAIN;
			end
			default: op_state = 1'b0;
		endcase
		// launch once on entry to each product step
		mul_start = op_state && !mstat.busy && !mstat.done;
	end

	// control, registers and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			sens_q      <= 16'd45875;
			pedal_q     <= 16'd19661;
			auto_q      <= 1'b1;
			attack_q    <= 16'd0;
			release_q   <= 16'd0;
			env_q       <= '0;
			i1_q        <= '0;
			i2_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				case (cfg_idx)
					REG_ENV_SENS: sens_q    <= cfg_wdata;
					REG_PEDAL:    pedal_q   <= cfg_wdata;
					REG_AUTO:     auto_q    <= cfg_wdata[0];
					REG_ATTACK:   attack_q  <= cfg_wdata;
					REG_RELEASE:  release_q <= cfg_wdata;
					default: ;
				endcase
			end
			// drop valid on transfer, raise on load
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (sample_out_valid && !sample_out_stall) out_valid_q <= 1'b0;
			if (state_q == S_ENV2 && mstat.done) env_q <= env_new;
			if (state_q == S_BP4 && mstat.done) begin
				i1_q <= sat32(i1_pre);
				i2_q <= sat32(i2_pre);
			end
		end
	end

	// per-sample payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q    <= sample_in;
			mag_q  <= mag_in;
			csel_q <= csel_in;
		end
		if (state_q == S_OUT && out_free) sample_out <= res_q;
		case (state_q)
			S_ENV1: if (mstat.done) t0_q <= prod;
			S_SE: begin
				if (mstat.done) begin
					se_q  <= se_new;
					pos_q <= pos_auto;
				end
			end
			S_MAN1: if (mstat.done) t0_q <= prod;
			S_MAN2: if (mstat.done) pos_q <= (pos_man > POS_FULL) ? POS_FULL : pos_man;
			S_IDX:  if (mstat.done) idx_q <= rnd16[16 +: IW];
			S_ROM:  v3_q <= v3_new;
			S_BP1:  if (mstat.done) v1_q <= VW'(rs30);
			S_BP2:  if (mstat.done) v1_q <= v1_new;
			S_BP3:  if (mstat.done) v2_q <= VW'(i2_q) + VW'(rs30);
			S_Y1:   if (mstat.done) y_q <= rs30;
			S_Y2:   if (mstat.done) res_q <= y_sat;
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> sample_in_stall)
		else $error("sample accepted but input not stalled next cycle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.done |=> !mstat.done)
		else $error("multiplier done held for more than one cycle");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_out_valid) |-> $past(state_q == S_OUT))
		else $error("output valid raised outside the output load step");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BP1) |-> (idx_q <= IW'(POSITION_STEPS - 1)))
		else $error("coefficient index beyond the table");
`endif

endmodule
`default_nettype wire

// ===== tb/swah_checker.sv =====
// Checker for the swept wah band-pass: predicts each output sample and compares.
`timescale 1ns / 1ps
module swah_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_in_valid,
	input  logic               sample_in_stall,
	input  logic signed [23:0] sample_in,
	input  logic               sample_out_valid,
	input  logic               sample_out_stall,
	input  logic signed [23:0] sample_out,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata,
	output int                 fail_count,
	output int                 pending,
	output int                 outputs_seen
);
	import swah_pkg::*;

	localparam int STEPS = 256;
	localparam longint FULL = 64'd8388608;

	longint unsigned a1_rom [STEPS];
	longint unsigned a2_rom [STEPS];
	longint unsigned a3_rom [STEPS];

	longint unsigned sens, pedal, auto_on, attack, release_c;
	longint unsigned env;
	longint          int1, int2;
	logic signed [23:0] expected_q [$];

	// floor division by 2^s with rounding half up
	function automatic longint rnd(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned mulq_l(input longint unsigned a,
		input longint unsigned b);
		return (a * (b >> 15) + ((a * (b & 32767)) >> 15)) >> 15;
	endfunction

	// square-root-free table entry: exp series, sin/cos series, TPT terms
	function automatic void build_rom();
		longint unsigned p, y, t, m, term, w, th, th2, g, den, a1, a2;
		longint s, c, st, ct;
		int unsigned n;
		for (int i = 0; i < STEPS; i++) begin
			p = longint'(i) * ONE30 / (STEPS - 1);
			y = mulq_l(p, LOG2_14_Q30);
			n = int'((y >> 30) & 3);
			t = mulq_l(y & (ONE30 - 1), LN2_Q30);
			m = ONE30;
			term = ONE30;
			for (int k = 1; k <= 14; k++) begin
				term = mulq_l(term, t) / k;
				m += term;
			end
			w = ((120 * m) << n) / 48000;
			if (w > WMAX_Q30) w = WMAX_Q30;
			th = mulq_l(w, PI_Q30);
			th2 = mulq_l(th, th);
			s = th; st = th; c = ONE30; ct = ONE30;
			for (int k = 1; k <= 10; k++) begin
				st = mulq_l(st, th2) / ((2 * k) * (2 * k + 1));
				ct = mulq_l(ct, th2) / ((2 * k - 1) * (2 * k));
				if (k % 2) begin
					s -= st; c -= ct;
				end else begin
					s += st; c += ct;
				end
			end
			if (s < 0) s = 0;
			if (c < 1) c = 1;
			g = (longint'(s) << 30) / c;
			den = ONE30 + mulq_l(g, g + K_Q30);
			a1 = (ONE30 << 30) / den;
			a2 = mulq_l(g, a1);
			a1_rom[i] = a1 & 32'hFFFFFFFF;
			a2_rom[i] = a2 & 32'hFFFFFFFF;
			a3_rom[i] = mulq_l(g, a2) & 32'hFFFFFFFF;
		end
	endfunction

	function automatic logic signed [23:0] wah_predict(input logic signed [23:0] smp);
		longint x, x27, v3, v1, v2, y;
		longint unsigned mag, coef, e, se, pos, idx;
		x = smp;
		mag = x < 0 ? -x : x;
		coef = (mag > env) ? attack : release_c;
		env = (coef * env + (65536 - coef) * mag + 32768) >> 16;
		e = env * 3;
		if (e > FULL) e = FULL;
		se = (sens * e + (FULL >> 1)) >> 23;
		if (auto_on) pos = 14418 + ((3 * se + 2) >> 2);
		else pos = (pedal * 45875 + se * 19661 + 32768) >> 16;
		if (pos > 65536) pos = 65536;
		idx = (pos * (STEPS - 1) + 32768) >> 16;
		if (idx > STEPS - 1) idx = STEPS - 1;
		x27 = x * 16;
		v3 = x27 - int2;
		v1 = rnd(longint'(a1_rom[idx]) * int1, 30) + rnd(longint'(a2_rom[idx]) * v3, 30);
		v2 = int2 + rnd(longint'(a2_rom[idx]) * int1, 30)
			+ rnd(longint'(a3_rom[idx]) * v3, 30);
		int1 = clip32(2 * v1 - int1);
		int2 = clip32(2 * v2 - int2);
		y = rnd(v1 * 64'sd511606399, 30) + rnd(x27 * 64'sd128849019, 30);
		y = rnd(y, 4);
		if (y > FULL - 1) y = FULL - 1;
		if (y < -FULL) y = -FULL;
		return y[23:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		fail_count++;
	endtask

	initial build_rom();

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens <= 45875; pedal <= 19661; auto_on <= 1; attack <= 0; release_c <= 0;
			env = 0; int1 = 0; int2 = 0;
			expected_q.delete();
			fail_count = 0;
			outputs_seen = 0;
		end else begin
			// outputs first: a sample accepted now cannot produce a result this edge
			if (sample_out_valid && !sample_out_stall) begin
				outputs_seen++;
				if (expected_q.size() == 0)
					report_mismatch($sformatf("unexpected output %0d", sample_out));
				else begin
					if (sample_out !== expected_q[0])
						report_mismatch($sformatf("sample_out got %0d want %0d",
							sample_out, expected_q[0]));
					void'(expected_q.pop_front());
				end
			end
			if (sample_in_valid && !sample_in_stall)
				expected_q.push_back(wah_predict(sample_in));
			if (cfg_wen) begin
				case (cfg_idx)
					REG_ENV_SENS: sens <= cfg_wdata;
					REG_PEDAL:    pedal <= cfg_wdata;
					REG_AUTO:     auto_on <= cfg_wdata[0];
					REG_ATTACK:   attack <= cfg_wdata;
					REG_RELEASE:  release_c <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the swept wah band-pass testbench.
`timescale 1ns / 1ps
module tb_top;
	import swah_pkg::*;

	localparam int WATCHDOG = 20000;

	logic               clk;
	logic               arst_n;
	logic               sample_in_valid;
	logic               sample_in_stall;
	logic signed [23:0] sample_in;
	logic               sample_out_valid;
	logic               sample_out_stall;
	logic signed [23:0] sample_out;
	logic               cfg_wen;
	logic [2:0]         cfg_idx;
	logic [15:0]        cfg_wdata;
	int                 fail_count, pending, outputs_seen;
	int                 idle_cycles;
	int                 samples_sent;
	bit                 sink_calm;    // no random stalls on the output
	bit                 hold_output;  // long output stall requested

	envelope_swept_wah_bandpass DUT (
		.clk, .arst_n, .sample_in_valid, .sample_in_stall, .sample_in,
		.sample_out_valid, .sample_out_stall, .sample_out, .cfg_wen, .cfg_idx, .cfg_wdata
	);

	swah_checker u_checker (
		.clk, .arst_n, .sample_in_valid, .sample_in_stall, .sample_in,
		.sample_out_valid, .sample_out_stall, .sample_out, .cfg_wen, .cfg_idx, .cfg_wdata,
		.fail_count, .pending, .outputs_seen
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: count cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((sample_in_valid && !sample_in_stall) || (sample_out_valid && !sample_out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("envelope_swept_wah_bandpass verification failed");
			$finish;
		end
	end

	// receiver: random stall bursts, a long hold on request, none when calm
	initial begin
		int n;
		sample_out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				sample_out_stall <= 1'b1;
				repeat (600) @(negedge clk);
				sample_out_stall <= 1'b0;
				hold_output = 0;
			end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 10);
				sample_out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				sample_out_stall <= 1'b0;
			end
		end
	end

	// offer one sample; hold it until the transfer, random gap before it
	task automatic send_sample(input logic signed [23:0] value, input bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			sample_in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		sample_in_valid <= 1'b1;
		sample_in <= value;
		// stall only moves at rising edges; check it between them
		while (sample_in_stall) @(negedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic drain_outputs();
		sample_in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// a sample may still be in flight after the last output; outlast it
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic signed [23:0] random_sample();
		case ($urandom_range(0, 5))
			0: return 24'sh800000;
			1: return 24'sh7FFFFF;
			2: return 24'($urandom_range(0, 255) - 128);
			default: return 24'($urandom());
		endcase
	endfunction

	// a burst of signal: an alternating tone of random amplitude that decays, which sweeps the filter
	task automatic send_swell(input bit gaps);
		int len;
		int amp;
		len = $urandom_range(8, 30);
		amp = $urandom_range(1, 8388607);
		for (int i = 0; i < len; i++)
			send_sample(24'(((i % 2) ? amp : -amp) / (1 + i / 4) + $urandom_range(0, 63)),
				gaps);
	endtask

	initial begin
		sample_in_valid = 1'b0;
		sample_in = '0;
		cfg_wen = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		sink_calm = 0;
		hold_output = 0;
		samples_sent = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes under default registers, then the pedal sweep
		send_sample(24'sh7FFFFF, 0);
		send_sample(24'sh800000, 0);
		send_sample(24'sh800000, 0);
		send_sample(24'sh000000, 0);
		send_sample(24'sh000001, 0);
		send_sample(-24'sd1, 0);
		for (int i = 0; i < 6; i++)
			send_sample((i % 2) ? 24'sh7FFFFF : 24'sh800000, 0);
		drain_outputs();
		write_reg(REG_AUTO, 16'h0000);
		write_reg(REG_PEDAL, 16'hFFFF);
		write_reg(REG_ENV_SENS, 16'hFFFF);
		write_reg(3'd7, 16'h1234);   // unmapped index must be ignored
		for (int i = 0; i < 8; i++)
			send_sample((i % 2) ? 24'sh7FFFFF : 24'sh800000, 0);
		drain_outputs();

		// random phases, each under a new register setting
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_ENV_SENS, ph == 0 ? 16'h0000 : 16'($urandom()));
			write_reg(REG_PEDAL, ph == 1 ? 16'h0000 : 16'($urandom()));
			write_reg(REG_AUTO, 16'($urandom()));
			write_reg(REG_ATTACK, ph == 2 ? 16'hFFFF : (ph == 3 ? 16'h0000 : 16'($urandom())));
			write_reg(REG_RELEASE, ph == 2 ? 16'hFFFF : (ph == 3 ? 16'h0000 : 16'($urandom())));
			if (ph == 4) hold_output = 1;
			if (ph == 7) sink_calm = 1;
			for (int n = 0; n < 50; n++) begin
				if ($urandom_range(0, 2) == 0) begin
					send_swell(ph != 7);
					n += 10;
				end else
					send_sample(random_sample(), ph != 7);
			end
			drain_outputs();
		end

		$display("Covered %0d samples and %0d outputs over ten register settings,",
			samples_sent, outputs_seen);
		$display("both sweep modes, extreme coefficients and a long output hold.");
		if (fail_count == 0)
			$display("envelope_swept_wah_bandpass verification clean");
		else
			$display("envelope_swept_wah_bandpass verification failed");
		$finish;
	end
endmodule
